>>> sv/rsvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsvd_pkg
// shared constants and types for the receive state record validator
// ----------------------------------------------------------------------------
package rsvd_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam logic [7:0] MAX_SUBGROUPS_RESET = 8'd4;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_SHORT      = 3'd1;
   localparam logic [2:0] ERR_ADDR_TYPE  = 3'd2;
   localparam logic [2:0] ERR_SET_ID     = 3'd3;
   localparam logic [2:0] ERR_SYNC_STATE = 3'd4;
   localparam logic [2:0] ERR_SUBGROUPS  = 3'd5;
   localparam logic [2:0] ERR_TRUNCATED  = 3'd6;

   typedef struct packed {
      logic       record_valid;
      logic [2:0] error_code;
      logic [7:0] source_ident;
      logic [7:0] encryption_state;
      logic [7:0] subgroup_total;
   } rsvd_result_type;

endpackage

>>> sv/rsvd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsvd_in_stage
// input register for one record byte, stalls while its byte cannot move on
// ----------------------------------------------------------------------------
module rsvd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       out_free,
   output logic       step,
   output logic [7:0] data_byte,
   output logic       last_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       accept;

   // a byte without a verdict never waits on the result side
   assign step      = valid_ff && (!last_ff || out_free);
   assign req_stall = valid_ff && !step;
   assign accept    = req_valid && !req_stall;
   assign data_byte = data_ff;
   assign last_byte = last_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

endmodule

>>> sv/rsvd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsvd_parser
// field walker: phase, counters, held fields and the verdict of a record
// ----------------------------------------------------------------------------
module rsvd_parser #(
   parameter int COUNT_BITS = rsvd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [7:0]                csr_data,
   input  logic                      step,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   output logic                      result_load,
   output rsvd_pkg::rsvd_result_type result
);

   localparam logic [3:0] PH_SRC        = 4'd0;
   localparam logic [3:0] PH_ADDR_TYPE  = 4'd1;
   localparam logic [3:0] PH_ADDR       = 4'd2;
   localparam logic [3:0] PH_SET_ID     = 4'd3;
   localparam logic [3:0] PH_BCAST_ID   = 4'd4;
   localparam logic [3:0] PH_SYNC_STATE = 4'd5;
   localparam logic [3:0] PH_ENC        = 4'd6;
   localparam logic [3:0] PH_BAD_CODE   = 4'd7;
   localparam logic [3:0] PH_NSUB       = 4'd8;
   localparam logic [3:0] PH_SUB_SYNC   = 4'd9;
   localparam logic [3:0] PH_META_LEN   = 4'd10;
   localparam logic [3:0] PH_META       = 4'd11;
   localparam logic [3:0] PH_DONE       = 4'd12;
   localparam logic [3:0] PH_FAULT      = 4'd13;

   localparam logic [7:0] ADDR_LEN         = 8'd6;
   localparam logic [7:0] BCAST_ID_LEN     = 8'd3;
   localparam logic [7:0] BAD_CODE_LEN     = 8'd16;
   localparam logic [7:0] SYNC_LEN         = 8'd4;
   localparam logic [7:0] MAX_ADDR_TYPE    = 8'd1;
   localparam logic [7:0] MAX_SET_ID       = 8'h0F;
   localparam logic [7:0] SYNC_STATE_LIMIT = 8'd5;
   localparam logic [7:0] ENC_BAD_CODE     = 8'd3;
   localparam logic [COUNT_BITS-1:0] MIN_RECORD_LEN = COUNT_BITS'(15);

   logic [7:0]            max_sub_ff;
   logic [3:0]            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]            skip_ff, skip_in;
   logic [7:0]            sub_ff, sub_in;
   logic [2:0]            fault_ff, fault_in;
   logic [7:0]            src_ff, src_in;
   logic [7:0]            enc_ff, enc_in;
   logic [7:0]            nsub_ff, nsub_in;
   logic [7:0]            skip_dec;
   logic [7:0]            sub_dec;
   logic [2:0]            code;

   assign skip_dec = (skip_ff != 8'd0) ? skip_ff - 8'd1 : skip_ff;
   assign sub_dec  = sub_ff - 8'd1;

   always_comb begin
      phase_in = phase_ff;
      skip_in  = skip_ff;
      sub_in   = sub_ff;
      fault_in = fault_ff;
      src_in   = src_ff;
      enc_in   = enc_ff;
      nsub_in  = nsub_ff;
      count_in = (count_ff != {COUNT_BITS{1'b1}}) ? count_ff + COUNT_BITS'(1) : count_ff;
      case (phase_ff)
         PH_SRC: begin
            src_in   = data_byte;
            phase_in = PH_ADDR_TYPE;
         end
         PH_ADDR_TYPE: begin
            if (data_byte > MAX_ADDR_TYPE) begin
               fault_in = rsvd_pkg::ERR_ADDR_TYPE;
               phase_in = PH_FAULT;
            end else begin
               phase_in = PH_ADDR;
               skip_in  = ADDR_LEN;
            end
         end
         PH_ADDR: begin
            skip_in = skip_dec;
            if (skip_dec == 8'd0) phase_in = PH_SET_ID;
         end
         PH_SET_ID: begin
            if (data_byte > MAX_SET_ID) begin
               fault_in = rsvd_pkg::ERR_SET_ID;
               phase_in = PH_FAULT;
            end else begin
               phase_in = PH_BCAST_ID;
               skip_in  = BCAST_ID_LEN;
            end
         end
         PH_BCAST_ID: begin
            skip_in = skip_dec;
            if (skip_dec == 8'd0) phase_in = PH_SYNC_STATE;
         end
         PH_SYNC_STATE: begin
            if (data_byte >= SYNC_STATE_LIMIT) begin
               fault_in = rsvd_pkg::ERR_SYNC_STATE;
               phase_in = PH_FAULT;
            end else begin
               phase_in = PH_ENC;
            end
         end
         PH_ENC: begin
            enc_in = data_byte;
            if (data_byte == ENC_BAD_CODE) begin
               phase_in = PH_BAD_CODE;
               skip_in  = BAD_CODE_LEN;
            end else begin
               phase_in = PH_NSUB;
            end
         end
         PH_BAD_CODE: begin
            skip_in = skip_dec;
            if (skip_dec == 8'd0) phase_in = PH_NSUB;
         end
         PH_NSUB: begin
            nsub_in = data_byte;
            if (data_byte > max_sub_ff) begin
               fault_in = rsvd_pkg::ERR_SUBGROUPS;
               phase_in = PH_FAULT;
            end else if (data_byte == 8'd0) begin
               phase_in = PH_DONE;
            end else begin
               sub_in   = data_byte;
               phase_in = PH_SUB_SYNC;
               skip_in  = SYNC_LEN;
            end
         end
         PH_SUB_SYNC: begin
            skip_in = skip_dec;
            if (skip_dec == 8'd0) phase_in = PH_META_LEN;
         end
         PH_META_LEN: begin
            if (data_byte == 8'd0) begin
               sub_in = sub_dec;
               if (sub_dec == 8'd0) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_SUB_SYNC;
                  skip_in  = SYNC_LEN;
               end
            end else begin
               phase_in = PH_META;
               skip_in  = data_byte;
            end
         end
         PH_META: begin
            skip_in = skip_dec;
            if (skip_dec == 8'd0) begin
               sub_in = sub_dec;
               if (sub_dec == 8'd0) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_SUB_SYNC;
                  skip_in  = SYNC_LEN;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (count_in < MIN_RECORD_LEN) begin
         code = rsvd_pkg::ERR_SHORT;
      end else if (fault_in != rsvd_pkg::ERR_NONE) begin
         code = fault_in;
      end else if (phase_in != PH_DONE) begin
         code = rsvd_pkg::ERR_TRUNCATED;
      end else begin
         code = rsvd_pkg::ERR_NONE;
      end
   end

   assign result_load             = step && last_byte;
   assign result.record_valid     = (code == rsvd_pkg::ERR_NONE);
   assign result.error_code       = code;
   assign result.source_ident     = src_in;
   assign result.encryption_state = enc_in;
   assign result.subgroup_total   = nsub_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_sub_ff <= rsvd_pkg::MAX_SUBGROUPS_RESET;
      end else if (csr_write) begin
         max_sub_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || result_load) begin
         phase_ff <= PH_SRC;
         count_ff <= '0;
         skip_ff  <= 8'd0;
         sub_ff   <= 8'd0;
         fault_ff <= rsvd_pkg::ERR_NONE;
         src_ff   <= 8'd0;
         enc_ff   <= 8'd0;
         nsub_ff  <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         skip_ff  <= skip_in;
         sub_ff   <= sub_in;
         fault_ff <= fault_in;
         src_ff   <= src_in;
         enc_ff   <= enc_in;
         nsub_ff  <= nsub_in;
      end
   end

endmodule

>>> sv/rsvd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsvd_out_stage
// result register holding one verdict until the consumer takes it
// ----------------------------------------------------------------------------
module rsvd_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  rsvd_pkg::rsvd_result_type result,
   output logic                      out_free,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsvd_pkg::rsvd_result_type rsp_result
);

   logic                      valid_ff, valid_in;
   rsvd_pkg::rsvd_result_type result_ff;

   assign out_free   = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

>>> sv/receive_state_record_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_state_record_validator
// checks a broadcast receive state record byte by byte, one verdict per record
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    data_byte, last_byte
//   rsp      out        rsp_valid/stall    record_valid, error_code, fields
//   csr      in         csr_valid/ready    max_subgroups (8 bits)
//
// one byte per cycle while req_stall is low; a verdict is valid on rsp once its last
// byte has passed the input register and then the result register
// synchronous reset clears phase, counters, held fields and both valid flags
// a byte without a verdict always moves on; only a last byte waits on rsp_stall
// ----------------------------------------------------------------------------
module receive_state_record_validator #(
   parameter int COUNT_BITS = rsvd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_record_valid,
   output logic [2:0] rsp_error_code,
   output logic [7:0] rsp_source_ident,
   output logic [7:0] rsp_encryption_state,
   output logic [7:0] rsp_subgroup_total,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic                      out_free;
   logic                      step;
   logic [7:0]                data_byte;
   logic                      last_byte;
   logic                      result_load;
   rsvd_pkg::rsvd_result_type result;
   rsvd_pkg::rsvd_result_type rsp_result;

   assign csr_ready = 1'b1;

   rsvd_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .out_free      (out_free),
      .step          (step),
      .data_byte     (data_byte),
      .last_byte     (last_byte)
   );

   rsvd_parser #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .step        (step),
      .data_byte   (data_byte),
      .last_byte   (last_byte),
      .result_load (result_load),
      .result      (result)
   );

   rsvd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (result_load),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_record_valid     = rsp_result.record_valid;
   assign rsp_error_code       = rsp_result.error_code;
   assign rsp_source_ident     = rsp_result.source_ident;
   assign rsp_encryption_state = rsp_result.encryption_state;
   assign rsp_subgroup_total   = rsp_result.subgroup_total;

endmodule

>>> dv/receive_state_record_validator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_state_record_validator_test
// drives whole receive state records one byte per transfer and checks every
// verdict against an in-bench parser model (typed rows: the table's code); the
// directed records come first, then random records under several max_subgroups
// settings, random gaps and stalls on both channels and a long receiver hold-off
// ----------------------------------------------------------------------------
module receive_state_record_validator_test;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 7;
   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 10;
   localparam int CSR_SETTLE   = 4;
   localparam int CUT_NONE     = -1;
   localparam int CUT_RANDOM   = -2;
   localparam int N_DIR        = 21;
   localparam int N_SETTINGS   = 5;

   localparam int         MIN_LEN        = 15;
   localparam logic [7:0] SET_ID_MAX     = 8'h0F;
   localparam logic [7:0] BAD_CODE_BYTES = 8'd16;
   localparam logic [7:0] SYNC_BYTES     = 8'd4;
   localparam logic [7:0] ADDR_BYTES     = 8'd6;
   localparam logic [7:0] BCAST_BYTES    = 8'd3;
   localparam logic [7:0] ADDR_TYPE_MAX  = 8'd1;
   localparam logic [7:0] SYNC_LIMIT     = 8'd5;
   localparam logic [7:0] ENC_BAD_CODE   = 8'd3;
   localparam logic [15:0] SEEN_MAX      = 16'hFFFF;

   typedef enum logic [3:0] {
      P_SRC, P_ADDR_TYPE, P_ADDR, P_SET_ID, P_BCAST, P_SYNC, P_ENC, P_BAD_CODE,
      P_NSUB, P_SUB_SYNC, P_META_LEN, P_META, P_DONE, P_FAULT
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] src;
      logic [7:0] atype;
      logic [7:0] setid;
      logic [7:0] sync;
      logic [7:0] enc;
      logic [7:0] nsub;
      int         mlen;
      int         cut;
      int         trail;
      bit         typed;
      logic [2:0] code;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_record_valid;
   logic [2:0] rsp_error_code;
   logic [7:0] rsp_source_ident;
   logic [7:0] rsp_encryption_state;
   logic [7:0] rsp_subgroup_total;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   always #HALF_PERIOD clock = ~clock;

   receive_state_record_validator u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_record_valid     (rsp_record_valid),
      .rsp_error_code       (rsp_error_code),
      .rsp_source_ident     (rsp_source_ident),
      .rsp_encryption_state (rsp_encryption_state),
      .rsp_subgroup_total   (rsp_subgroup_total),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   // parser model state
   parse_phase_type phase;
   logic [15:0]  seen;
   logic [7:0]   skip_left;
   logic [7:0]   subs_left;
   logic [2:0]   fault_code;
   logic [7:0]   keep_src;
   logic [7:0]   keep_enc;
   logic [7:0]   keep_nsub;
   logic [7:0]   cfg_max;

   rsvd_pkg::rsvd_result_type verdicts_due[$];
   logic [7:0]      rec_q[$];
   dir_row_type     dir_rows [N_DIR];
   int              fails;
   int              idle_cycles;
   bit              no_idle;
   bit              hold_rsp;
   bit              quiet_rsp;
   bit              watch_on;

   function automatic void clear_parser();
      phase      = P_SRC;
      seen       = '0;
      skip_left  = '0;
      subs_left  = '0;
      fault_code = rsvd_pkg::ERR_NONE;
      keep_src   = '0;
      keep_enc   = '0;
      keep_nsub  = '0;
   endfunction

   function automatic bit skip_done();
      if (skip_left != 0) skip_left--;
      return skip_left == 0;
   endfunction

   function automatic void close_subgroup();
      subs_left--;
      if (subs_left == 0) begin
         phase = P_DONE;
      end else begin
         phase     = P_SUB_SYNC;
         skip_left = SYNC_BYTES;
      end
   endfunction

   function automatic void set_fault(logic [2:0] code);
      fault_code = code;
      phase      = P_FAULT;
   endfunction

   function automatic bit step_record_parser(input logic [7:0] b, input logic last,
                                             output rsvd_pkg::rsvd_result_type verdict);
      logic [2:0] code;
      verdict = '0;
      if (seen != SEEN_MAX) seen++;
      case (phase)
         P_SRC: begin
            keep_src = b;
            phase    = P_ADDR_TYPE;
         end
         P_ADDR_TYPE: begin
            if (b > ADDR_TYPE_MAX) set_fault(rsvd_pkg::ERR_ADDR_TYPE);
            else begin
               phase     = P_ADDR;
               skip_left = ADDR_BYTES;
            end
         end
         P_ADDR: if (skip_done()) phase = P_SET_ID;
         P_SET_ID: begin
            if (b > SET_ID_MAX) set_fault(rsvd_pkg::ERR_SET_ID);
            else begin
               phase     = P_BCAST;
               skip_left = BCAST_BYTES;
            end
         end
         P_BCAST: if (skip_done()) phase = P_SYNC;
         P_SYNC: begin
            if (b >= SYNC_LIMIT) set_fault(rsvd_pkg::ERR_SYNC_STATE);
            else phase = P_ENC;
         end
         P_ENC: begin
            keep_enc = b;
            if (b == ENC_BAD_CODE) begin
               phase     = P_BAD_CODE;
               skip_left = BAD_CODE_BYTES;
            end else begin
               phase = P_NSUB;
            end
         end
         P_BAD_CODE: if (skip_done()) phase = P_NSUB;
         P_NSUB: begin
            keep_nsub = b;
            if (b > cfg_max) set_fault(rsvd_pkg::ERR_SUBGROUPS);
            else if (b == 0) phase = P_DONE;
            else begin
               subs_left = b;
               phase     = P_SUB_SYNC;
               skip_left = SYNC_BYTES;
            end
         end
         P_SUB_SYNC: if (skip_done()) phase = P_META_LEN;
         P_META_LEN: begin
            if (b == 0) close_subgroup();
            else begin
               phase     = P_META;
               skip_left = b;
            end
         end
         P_META: if (skip_done()) close_subgroup();
         default: ;
      endcase
      if (!last) return 1'b0;
      if (seen < MIN_LEN) code = rsvd_pkg::ERR_SHORT;
      else if (fault_code != rsvd_pkg::ERR_NONE) code = fault_code;
      else if (phase != P_DONE) code = rsvd_pkg::ERR_TRUNCATED;
      else code = rsvd_pkg::ERR_NONE;
      verdict.record_valid     = (code == rsvd_pkg::ERR_NONE);
      verdict.error_code       = code;
      verdict.source_ident     = keep_src;
      verdict.encryption_state = keep_enc;
      verdict.subgroup_total   = keep_nsub;
      clear_parser();
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int meta_len_pick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 255);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         fails++;
      end
   endfunction

   task automatic check_verdict();
      rsvd_pkg::rsvd_result_type want;
      if (verdicts_due.size() == 0) begin
         $error("verdict with none due, error_code %0d", rsp_error_code);
         fails++;
         return;
      end
      want = verdicts_due.pop_front();
      check_field("record_valid", 8'(want.record_valid), 8'(rsp_record_valid));
      check_field("error_code", 8'(want.error_code), 8'(rsp_error_code));
      check_field("source_ident", want.source_ident, rsp_source_ident);
      check_field("encryption_state", want.encryption_state, rsp_encryption_state);
      check_field("subgroup_total", want.subgroup_total, rsp_subgroup_total);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                            input logic [2:0] code);
      rsvd_pkg::rsvd_result_type v;
      int g;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (step_record_parser(b, last, v)) begin
         if (typed) begin
            v.record_valid = (code == rsvd_pkg::ERR_NONE);
            v.error_code   = code;
         end
         verdicts_due.push_back(v);
      end
      g = no_idle ? 0 : pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_record(input bit typed, input logic [2:0] code);
      foreach (rec_q[i]) send_byte(rec_q[i], i == rec_q.size() - 1, typed, code);
   endtask

   task automatic build_record(input logic [7:0] src, atype, setid, sync, enc, nsub,
                               input int mlen, input int cut, input int trail);
      int m;
      int keep;
      rec_q.delete();
      rec_q.push_back(src);
      rec_q.push_back(atype);
      repeat (ADDR_BYTES) rec_q.push_back(8'($urandom));
      rec_q.push_back(setid);
      repeat (BCAST_BYTES) rec_q.push_back(8'($urandom));
      rec_q.push_back(sync);
      rec_q.push_back(enc);
      if (enc == ENC_BAD_CODE) repeat (BAD_CODE_BYTES) rec_q.push_back(8'($urandom));
      rec_q.push_back(nsub);
      repeat (nsub) begin
         repeat (SYNC_BYTES) rec_q.push_back(8'($urandom));
         m = (mlen < 0) ? meta_len_pick() : mlen;
         rec_q.push_back(8'(m));
         repeat (m) rec_q.push_back(8'($urandom));
      end
      repeat (trail) rec_q.push_back(8'($urandom));
      keep = cut;
      if (keep == CUT_RANDOM && rec_q.size() > 1) keep = $urandom_range(1, rec_q.size() - 1);
      if (keep > 0 && keep < rec_q.size()) rec_q = rec_q[0:keep-1];
   endtask

   task automatic random_record();
      logic [7:0] src, atype, setid, sync, enc, nsub;
      int kind, trail, cut, top, wide;
      src   = 8'($urandom);
      atype = 8'($urandom_range(0, 1));
      setid = 8'($urandom_range(0, int'(SET_ID_MAX)));
      sync  = 8'($urandom_range(0, int'(SYNC_LIMIT) - 1));
      enc   = ($urandom_range(0, 3) == 0) ? ENC_BAD_CODE : 8'($urandom);
      top   = (cfg_max < 5) ? int'(cfg_max) : 5;
      wide  = (cfg_max < 12) ? int'(cfg_max) : 12;
      nsub  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, wide))
                                          : 8'($urandom_range(0, top));
      trail = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 4) : 0;
      cut   = CUT_NONE;
      kind  = $urandom_range(0, 99);
      if (kind >= 95) ;
      else if (kind >= 86) cut = CUT_RANDOM;
      else if (kind >= 80) begin
         if (cfg_max != 8'hFF) begin
            nsub = 8'($urandom_range(int'(cfg_max) + 1, 255));
            // end the record at the subgroup count or up to four bytes past it
            cut  = ((enc == ENC_BAD_CODE) ? 31 : 15) + int'($urandom_range(0, 4));
         end
      end
      else if (kind >= 74) sync = 8'($urandom_range(int'(SYNC_LIMIT), 255));
      else if (kind >= 68) setid = 8'($urandom_range(int'(SET_ID_MAX) + 1, 255));
      else if (kind >= 60) atype = 8'($urandom_range(2, 255));
      build_record(src, atype, setid, sync, enc, nsub, (nsub > 8) ? 0 : -1, cut, trail);
      if (kind >= 95) begin
         // noise record
         rec_q.delete();
         repeat ($urandom_range(1, 30)) rec_q.push_back(8'($urandom));
      end
      no_idle = ($urandom_range(0, 4) == 0);
      send_record(1'b0, rsvd_pkg::ERR_NONE);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_subgroups(input logic [7:0] v);
      wait_drained();
      repeat (CSR_SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_max = v;
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0] settings [N_SETTINGS];
      int phase_records;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      csr_valid     <= 1'b0;
      csr_data      <= '0;
      fails   = 0;
      cfg_max = rsvd_pkg::MAX_SUBGROUPS_RESET;
      clear_parser();
      dir_rows = '{
         '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0, 1'b1, rsvd_pkg::ERR_SHORT},
         '{8'h5A, 8'h01, 8'h0F, 8'h04, 8'h00, 8'h00, 0, 14, 0, 1'b1, rsvd_pkg::ERR_SHORT},
         '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, CUT_NONE, 0, 1'b1, rsvd_pkg::ERR_NONE},
         '{8'hFF, 8'h01, 8'h0F, 8'h04, 8'hFF, 8'h04, 0, CUT_NONE, 0, 1'b1, rsvd_pkg::ERR_NONE},
         '{8'h11, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 0, CUT_NONE, 0, 1'b1,
           rsvd_pkg::ERR_ADDR_TYPE},
         '{8'h12, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 0, CUT_NONE, 0, 1'b1,
           rsvd_pkg::ERR_ADDR_TYPE},
         '{8'h13, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 0, CUT_NONE, 0, 1'b1,
           rsvd_pkg::ERR_SET_ID},
         '{8'h14, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 0, CUT_NONE, 0, 1'b1,
           rsvd_pkg::ERR_SET_ID},
         '{8'h15, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 0, CUT_NONE, 0, 1'b1,
           rsvd_pkg::ERR_SYNC_STATE},
         '{8'h16, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 0, CUT_NONE, 0, 1'b1,
           rsvd_pkg::ERR_SYNC_STATE},
         '{8'h17, 8'h05, 8'h00, 8'h09, 8'h00, 8'h00, 0, CUT_NONE, 0, 1'b1,
           rsvd_pkg::ERR_ADDR_TYPE},
         '{8'h18, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 0, 16, 0, 1'b1, rsvd_pkg::ERR_SUBGROUPS},
         '{8'h19, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 0, 16, 0, 1'b1, rsvd_pkg::ERR_SUBGROUPS},
         '{8'h20, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 2, CUT_NONE, 0, 1'b1, rsvd_pkg::ERR_NONE},
         '{8'h21, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 0, 20, 0, 1'b1, rsvd_pkg::ERR_TRUNCATED},
         '{8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 3, 26, 0, 1'b1, rsvd_pkg::ERR_TRUNCATED},
         '{8'h23, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 0, 17, 0, 1'b1, rsvd_pkg::ERR_TRUNCATED},
         '{8'h24, 8'h01, 8'h03, 8'h02, 8'h80, 8'h00, 0, CUT_NONE, 5, 1'b1, rsvd_pkg::ERR_NONE},
         '{8'h25, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 0, 10, 0, 1'b1, rsvd_pkg::ERR_SHORT},
         '{8'h26, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 16, CUT_NONE, 0, 1'b0, rsvd_pkg::ERR_NONE},
         '{8'h27, 8'h01, 8'h07, 8'h03, 8'h01, 8'h01, -1, CUT_NONE, 2, 1'b0, rsvd_pkg::ERR_NONE}
      };
      settings = '{8'h00, 8'hFF, 8'h01, 8'($urandom_range(2, 254)),
                   rsvd_pkg::MAX_SUBGROUPS_RESET};
      repeat (RESET_CYCLES) @(posedge clock);
      reset    <= 1'b0;
      watch_on  = 1'b1;

      foreach (dir_rows[i]) begin
         build_record(dir_rows[i].src, dir_rows[i].atype, dir_rows[i].setid, dir_rows[i].sync,
                      dir_rows[i].enc, dir_rows[i].nsub, dir_rows[i].mlen, dir_rows[i].cut,
                      dir_rows[i].trail);
         no_idle = ($urandom_range(0, 3) == 0);
         send_record(dir_rows[i].typed, dir_rows[i].code);
      end

      foreach (settings[p]) begin
         write_max_subgroups(settings[p]);
         phase_records = 0;
         while (phase_records < ((p == 1) ? 3 : 1)) begin
            // receiver hold-off while records keep coming
            if (p == 1 && phase_records == 0) hold_rsp = 1'b1;
            random_record();
            phase_records++;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_verdict();
         if ($urandom_range(0, 199) == 0) quiet_rsp = !quiet_rsp;
         if (hold_rsp) begin
            hold_rsp   = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !quiet_rsp) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (watch_on) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else
            idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
